FILE: src/bitbang_i2c_byte_master_macros.svh
// assertion macros used by the checker file
`ifndef BITBANG_I2C_BYTE_MASTER_MACROS_SVH
`define BITBANG_I2C_BYTE_MASTER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BBI2C_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define BBI2C_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: src/bbi2c_pkg.sv
// shared types, codes and phase decode functions for the i2c byte master
package bbi2c_pkg;

    localparam int TIMER_WIDTH_DEFAULT = 16;
    localparam logic [15:0] PHASE_LEN_RESET = 16'd10;
    localparam logic [2:0] BIT_TOP = 3'd7;

    // command codes as they arrive on the input word
    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_INIT  = 3'd1;
    localparam logic [2:0] KIND_START = 3'd2;
    localparam logic [2:0] KIND_STOP  = 3'd3;
    localparam logic [2:0] KIND_WRITE = 3'd4;
    localparam logic [2:0] KIND_READ  = 3'd5;

    // phase counts per command
    localparam logic [4:0] NPH_INIT  = 5'd3;
    localparam logic [4:0] NPH_START = 5'd3;
    localparam logic [4:0] NPH_STOP  = 5'd4;
    localparam logic [4:0] NPH_WRITE = 5'd27;
    localparam logic [4:0] NPH_READ  = 5'd20;

    // landmark phases of write and read
    localparam logic [4:0] WR_BITS_END = 5'd24;
    localparam logic [4:0] WR_ACK_SCL  = 5'd25;
    localparam logic [4:0] RD_BITS_END = 5'd16;
    localparam logic [4:0] RD_ACK_SCL  = 5'd17;
    localparam logic [4:0] RD_ACK_LOW  = 5'd18;

    // reciprocal of three for phase numbers below 24
    localparam logic [9:0] RECIP3 = 10'd11;

    typedef enum logic [5:0] {
        CMD_IDLE  = 6'b000001,
        CMD_INIT  = 6'b000010,
        CMD_START = 6'b000100,
        CMD_STOP  = 6'b001000,
        CMD_WRITE = 6'b010000,
        CMD_READ  = 6'b100000
    } cmd_t;

    typedef struct packed {
        logic scl;
        logic sda;
    } lines_t;

    typedef struct packed {
        logic [7:0] rx;
        logic       ack;
        logic       done;
        logic       busy;
        logic       sda;
        logic       scl;
    } seq_res_t;

    function automatic cmd_t kind_to_cmd(input logic [2:0] kind);
        cmd_t c;
        case (kind)
            KIND_INIT:  c = CMD_INIT;
            KIND_START: c = CMD_START;
            KIND_STOP:  c = CMD_STOP;
            KIND_WRITE: c = CMD_WRITE;
            KIND_READ:  c = CMD_READ;
            default:    c = CMD_IDLE;
        endcase
        return c;
    endfunction

    function automatic logic [4:0] phase_count(input cmd_t cmd);
        logic [4:0] n;
        case (cmd)
            CMD_INIT:  n = NPH_INIT;
            CMD_START: n = NPH_START;
            CMD_STOP:  n = NPH_STOP;
            CMD_WRITE: n = NPH_WRITE;
            CMD_READ:  n = NPH_READ;
            default:   n = 5'd0;
        endcase
        return n;
    endfunction

    // pin action applied when phase s of a command begins
    function automatic lines_t begin_phase(input cmd_t cmd, input logic [4:0] s,
                                           input logic [7:0] shift, input logic nack,
                                           input lines_t cur);
        lines_t     l;
        logic [9:0] prod;
        logic [2:0] q;
        logic [4:0] r;
        l    = cur;
        prod = {5'd0, s} * RECIP3;
        q    = prod[7:5];
        r    = s - {q, 1'b0} - {2'd0, q};
        case (cmd)
            CMD_INIT: begin
                if (s == 5'd0) l.scl = 1'b1;
                else if (s == 5'd1) l.sda = 1'b1;
            end
            CMD_START: begin
                if (s == 5'd0) l.sda = 1'b0;
                else if (s == 5'd1) l.scl = 1'b0;
            end
            CMD_STOP: begin
                if (s == 5'd0) l.sda = 1'b0;
                else if (s == 5'd1) l.scl = 1'b1;
                else if (s == 5'd2) l.sda = 1'b1;
            end
            CMD_WRITE: begin
                if (s < WR_BITS_END) begin
                    if (r == 5'd0) l.sda = shift[BIT_TOP - q];
                    else if (r == 5'd1) l.scl = 1'b1;
                    else l.scl = 1'b0;
                end else if (s == WR_BITS_END) begin
                    l.sda = 1'b1;
                end else if (s == WR_ACK_SCL) begin
                    l.scl = 1'b1;
                end else begin
                    l.scl = 1'b0;
                end
            end
            CMD_READ: begin
                if (s < RD_BITS_END) l.scl = ~s[0];
                else if (s == RD_BITS_END) l.sda = nack;
                else if (s == RD_ACK_SCL) l.scl = 1'b1;
                else if (s == RD_ACK_LOW) l.scl = 1'b0;
                else l.sda = 1'b1;
            end
            default: begin
                l = cur;
            end
        endcase
        return l;
    endfunction

endpackage

FILE: src/bbi2c_seq.sv
// command sequencer: phase timer, step counter and pin levels, one tick per word
module bbi2c_seq
    import bbi2c_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        tick,
    input  logic [2:0]  kind,
    input  logic [7:0]  tx_data,
    input  logic        send_nack,
    input  logic        sda_in,
    input  logic [15:0] phase_len,
    output seq_res_t    res
);

    logic [TIMER_WIDTH-1:0] timer_reg, timer_next;
    logic [4:0]             step_reg, step_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [7:0]             shift_reg, shift_next;
    logic                   nack_reg, nack_next;
    logic                   ack_reg, ack_next;
    lines_t                 lines_reg, lines_next;
    logic [7:0]             rx_reg, rx_next;
    logic                   done;

    logic [TIMER_WIDTH+15:0] len_ext;
    logic [TIMER_WIDTH-1:0]  len_raw, len, timer_inc;
    logic [4:0]              step_inc;
    cmd_t                    cmd_new;

    // phase length masked to the timer width, zero acts as one
    assign len_ext   = {{TIMER_WIDTH{1'b0}}, phase_len};
    assign len_raw   = len_ext[TIMER_WIDTH-1:0];
    assign len       = (len_raw == '0) ? {{(TIMER_WIDTH-1){1'b0}}, 1'b1} : len_raw;
    assign cmd_new   = kind_to_cmd(kind);

    always_comb begin
        cmd_next   = cmd_reg;
        step_next  = step_reg;
        timer_next = timer_reg;
        shift_next = shift_reg;
        nack_next  = nack_reg;
        ack_next   = ack_reg;
        lines_next = lines_reg;
        rx_next    = rx_reg;
        done       = 1'b0;
        timer_inc  = '0;
        step_inc   = '0;

        if (tick) begin
            // take a new command only while idle
            if (cmd_reg == CMD_IDLE && cmd_new != CMD_IDLE) begin
                cmd_next   = cmd_new;
                step_next  = '0;
                timer_next = '0;
                if (cmd_new == CMD_WRITE) begin
                    shift_next = tx_data;
                    ack_next   = 1'b0;
                end else if (cmd_new == CMD_READ) begin
                    shift_next = '0;
                    nack_next  = send_nack;
                end
                lines_next = begin_phase(cmd_new, 5'd0, shift_next, nack_next, lines_reg);
            end

            if (cmd_next != CMD_IDLE) begin
                timer_inc = timer_next + {{(TIMER_WIDTH-1){1'b0}}, 1'b1};
                if (timer_inc >= len) begin
                    if (cmd_next == CMD_WRITE && step_next == WR_ACK_SCL) begin
                        ack_next = ~sda_in;
                    end else if (cmd_next == CMD_READ && step_next < RD_BITS_END
                                 && !step_next[0]) begin
                        shift_next = {shift_next[6:0], sda_in};
                    end
                    timer_next = '0;
                    step_inc   = step_next + 5'd1;
                    if (step_inc >= phase_count(cmd_next)) begin
                        if (cmd_next == CMD_READ) rx_next = shift_next;
                        cmd_next  = CMD_IDLE;
                        step_next = '0;
                        done      = 1'b1;
                    end else begin
                        step_next  = step_inc;
                        lines_next = begin_phase(cmd_next, step_inc, shift_next,
                                                 nack_next, lines_next);
                    end
                end else begin
                    timer_next = timer_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_reg <= '0;
            step_reg  <= '0;
            cmd_reg   <= CMD_IDLE;
            shift_reg <= '0;
            nack_reg  <= 1'b0;
            ack_reg   <= 1'b0;
            lines_reg <= '{scl: 1'b1, sda: 1'b1};
            rx_reg    <= '0;
        end else begin
            timer_reg <= timer_next;
            step_reg  <= step_next;
            cmd_reg   <= cmd_next;
            shift_reg <= shift_next;
            nack_reg  <= nack_next;
            ack_reg   <= ack_next;
            lines_reg <= lines_next;
            rx_reg    <= rx_next;
        end
    end

    assign res.scl  = lines_next.scl;
    assign res.sda  = lines_next.sda;
    assign res.busy = (cmd_next != CMD_IDLE);
    assign res.done = done;
    assign res.ack  = ack_next;
    assign res.rx   = rx_next;

endmodule

FILE: src/bitbang_i2c_byte_master.sv
// top level of the bit-banged i2c byte master: stream ports, config register, output register
// Each input word is one timebase tick. It carries the sampled SDA level and,
// while the block is idle, a command: init, start, stop, write byte or read byte.
// A command is cut into pin phases of phase_len ticks each (zero acts as one);
// a command that arrives while one is running is ignored. For every tick word
// the block returns one word with the SCL and SDA levels to drive after that
// tick, busy, a done pulse on the finishing tick, the ACK seen by the last write
// and the last byte read. Throughput is one word per clock: the sequencer state
// is updated in the cycle the word is taken and the result lands in a single
// output register, so the output word is valid in the cycle after the input
// word is taken. The input stalls only while that output register is full and
// not being drained. phase_len may be written only while no command is running.
module bitbang_i2c_byte_master
    import bbi2c_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // phase length register
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // tick words in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // tx_data[7:0], send_nack[8], sda_in[9], zero[15:10]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    // result words out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // scl[0], sda_out[1], busy_res[2], done_res[3],
                                   // ack_ok[4], rx_data[12:5], zero[15:13]
);

    logic [15:0] phase_len_reg;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [15:0] m_tdata_reg, m_tdata_next;
    logic        in_accept;
    seq_res_t    res;

    // output register may take a word when empty or draining this cycle
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    // phase length register, reset to the default length
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_len_reg <= PHASE_LEN_RESET;
        end else if (cfg_we) begin
            phase_len_reg <= cfg_wdata;
        end
    end

    bbi2c_seq #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tick      (in_accept),
        .kind      (s_tuser),
        .tx_data   (s_tdata[7:0]),
        .send_nack (s_tdata[8]),
        .sda_in    (s_tdata[9]),
        .phase_len (phase_len_reg),
        .res       (res)
    );

    // output register: load on every accepted tick, clear once taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (in_accept) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {3'd0, res.rx, res.ack, res.done, res.busy,
                             res.sda, res.scl};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: src/bbi2c_checker.sv
// port-level checker for the i2c byte master and its bind
`include "bitbang_i2c_byte_master_macros.svh"

module bbi2c_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a finishing tick never reports busy
    `BBI2C_ASSERT_NOW(a_done_not_busy, m_tvalid && m_tdata[3], !m_tdata[2], "done with busy set")

    // empty output register must never stall the input
    `BBI2C_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready, "input stalled while output empty")

    // every accepted tick produces a result word next cycle
    `BBI2C_ASSERT_NEXT(a_accept_gives_word, s_tvalid && s_tready, m_tvalid, "accepted tick lost")

    // a stalled result word holds
    `BBI2C_ASSERT_NEXT(a_hold_on_stall, m_tvalid && !m_tready,
                       m_tvalid && $stable(m_tdata), "stalled word changed")

endmodule

bind bitbang_i2c_byte_master bbi2c_checker u_bbi2c_checker (.*);

FILE: sim/bitbang_i2c_byte_master_tb.sv
// self-checking testbench for the bit-banged i2c byte master, predictor-based
`timescale 1ns / 100ps

module bitbang_i2c_byte_master_tb;
    import bbi2c_pkg::*;

    // unused kind codes, the block treats them as a plain tick
    localparam logic [2:0] KIND_SPARE6 = 3'd6;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;

    // cycles with no handshake on either side before the run is called dead
    localparam int WATCHDOG_LIMIT    = 2000;
    // settle time after the last result, output register depth is one
    localparam int DRAIN_CYCLES      = 8;
    localparam int WORDS_PER_SETTING = 60;
    localparam int NUM_SETTINGS      = 2;

    // phase landmarks of the byte commands
    localparam int WR_DATA_PHASES = 24;   // eight bits, three phases each
    localparam int WR_RELEASE     = 24;
    localparam int WR_ACK         = 25;
    localparam int RD_DATA_PHASES = 16;   // eight bits, two phases each
    localparam int RD_ACK_DRIVE   = 16;
    localparam int RD_ACK_HIGH    = 17;
    localparam int RD_ACK_LOW     = 18;

    // result word as it sits on m_tdata, lowest field last
    typedef struct packed {
        logic [2:0] pad;
        logic [7:0] rx;
        logic       ack;
        logic       done;
        logic       busy;
        logic       sda;
        logic       scl;
    } line_word_t;

    // one directed command: the command word, the line level the slave shows,
    // the kind put on the ticks that follow while busy, and an optional typed result
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  tx;
        logic        nack;
        logic [7:0]  sda_bits;   // bits the slave puts out on a read, msb first
        logic        sda_ack;    // level seen during ack and all other phases
        logic [2:0]  filler;
        logic        typed;
        logic [15:0] want;       // result of the command word when typed
    } dir_row_t;

    localparam int DIR_ROWS = 15;
    // rows from here on run with a phase length of one
    localparam int DIR_LEN_ONE_ROW = 3;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // bus levels straight out of reset
        '{KIND_TICK,   8'h00, 1'b0, 8'h00, 1'b1, KIND_TICK,   1'b1, 16'h0003},
        '{KIND_SPARE6, 8'hFF, 1'b1, 8'h00, 1'b1, KIND_TICK,   1'b1, 16'h0003},
        '{KIND_SPARE7, 8'h00, 1'b0, 8'h00, 1'b0, KIND_TICK,   1'b1, 16'h0003},
        // init then start: busy rises on the accepting tick
        '{KIND_INIT,   8'h00, 1'b0, 8'h00, 1'b1, KIND_TICK,   1'b1, 16'h0007},
        '{KIND_START,  8'h00, 1'b0, 8'h00, 1'b1, KIND_TICK,   1'b1, 16'h0004},
        // data byte extremes, acked then not acked (ack flag clears on accept)
        '{KIND_WRITE,  8'hFF, 1'b0, 8'h00, 1'b0, KIND_TICK,   1'b1, 16'h0007},
        '{KIND_WRITE,  8'h00, 1'b0, 8'h00, 1'b1, KIND_TICK,   1'b1, 16'h0005},
        // reads, writes and a stop, most with commands thrown in while busy that must be dropped
        '{KIND_WRITE,  8'hA5, 1'b1, 8'h00, 1'b0, KIND_READ,   1'b0, 16'h0000},
        '{KIND_READ,   8'h00, 1'b0, 8'hFF, 1'b1, KIND_TICK,   1'b0, 16'h0000},
        '{KIND_READ,   8'hFF, 1'b0, 8'hA5, 1'b0, KIND_STOP,   1'b0, 16'h0000},
        '{KIND_READ,   8'h00, 1'b1, 8'h00, 1'b1, KIND_WRITE,  1'b0, 16'h0000},
        '{KIND_STOP,   8'h00, 1'b0, 8'h00, 1'b1, KIND_START,  1'b0, 16'h0000},
        // read right after start: sda is still held low by the master
        '{KIND_START,  8'h00, 1'b0, 8'h00, 1'b1, KIND_TICK,   1'b0, 16'h0000},
        '{KIND_READ,   8'h00, 1'b1, 8'h3C, 1'b0, KIND_TICK,   1'b0, 16'h0000},
        '{KIND_STOP,   8'h00, 1'b0, 8'h00, 1'b0, KIND_INIT,   1'b0, 16'h0000}
    };

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // tx_data[7:0], send_nack[8], sda_in[9], zero[15:10]
    logic [2:0]  s_tuser;    // kind[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // scl[0], sda_out[1], busy_res[2], done_res[3],
                             // ack_ok[4], rx_data[12:5], zero[15:13]

    // predictor copy of the sequencer
    logic [15:0] tick_len     = PHASE_LEN_RESET;
    logic [15:0] phase_ticks  = '0;
    logic [4:0]  phase_no     = '0;
    logic [2:0]  running      = KIND_TICK;   // tick code doubles as idle
    logic [7:0]  byte_shift   = '0;
    logic        nack_pending = 1'b0;
    logic        acked        = 1'b0;
    logic        scl_drv      = 1'b1;
    logic        sda_drv      = 1'b1;
    logic [7:0]  last_rx      = '0;

    line_word_t  levels_due [$];   // expected result words, oldest first
    line_word_t  predicted;
    line_word_t  got;
    line_word_t  want;

    // typed expectation for the word now on the input, set by the sender
    logic        fixed_valid = 1'b0;
    logic [15:0] fixed_word  = '0;

    logic        quiet = 1'b0;     // no idling on either side while set
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          results_seen = 0;
    int          words_sent = 0;

    bitbang_i2c_byte_master u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 50 MHz
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int phases_of(input logic [2:0] kind);
        case (kind)
            KIND_INIT:  return 3;
            KIND_START: return 3;
            KIND_STOP:  return 4;
            KIND_WRITE: return 27;
            KIND_READ:  return 20;
            default:    return 0;
        endcase
    endfunction

    // pin action taken as phase s of the running command begins
    function automatic void start_phase(input logic [4:0] s);
        int bit_no;
        int slot;
        bit_no = 7 - s / 3;
        slot   = s % 3;
        case (running)
            KIND_INIT: begin
                if (s == 0) scl_drv = 1'b1;
                else if (s == 1) sda_drv = 1'b1;
            end
            KIND_START: begin
                if (s == 0) sda_drv = 1'b0;
                else if (s == 1) scl_drv = 1'b0;
            end
            KIND_STOP: begin
                if (s == 0) sda_drv = 1'b0;
                else if (s == 1) scl_drv = 1'b1;
                else if (s == 2) sda_drv = 1'b1;
            end
            KIND_WRITE: begin
                if (s < WR_DATA_PHASES) begin
                    // data setup, clock high, clock low per bit
                    if (slot == 0) sda_drv = byte_shift[bit_no];
                    else if (slot == 1) scl_drv = 1'b1;
                    else scl_drv = 1'b0;
                end else if (s == WR_RELEASE) begin
                    sda_drv = 1'b1;
                end else if (s == WR_ACK) begin
                    scl_drv = 1'b1;
                end else begin
                    scl_drv = 1'b0;
                end
            end
            KIND_READ: begin
                if (s < RD_DATA_PHASES) scl_drv = ~s[0];
                else if (s == RD_ACK_DRIVE) sda_drv = nack_pending;
                else if (s == RD_ACK_HIGH) scl_drv = 1'b1;
                else if (s == RD_ACK_LOW) scl_drv = 1'b0;
                else sda_drv = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // advance the predictor by one tick word and return the levels after it
    function automatic line_word_t predict_tick(input logic [2:0] kind, input logic [7:0] tx,
                                                input logic nack, input logic sda);
        line_word_t  w;
        logic [15:0] len;
        logic        done;
        len  = (tick_len == 16'd0) ? 16'd1 : tick_len;
        done = 1'b0;
        // a command is taken only when idle, kinds six and seven never start one
        if (running == KIND_TICK && kind >= KIND_INIT && kind <= KIND_READ) begin
            running     = kind;
            phase_no    = '0;
            phase_ticks = '0;
            if (kind == KIND_WRITE) begin
                byte_shift = tx;
                acked      = 1'b0;
            end else if (kind == KIND_READ) begin
                byte_shift   = '0;
                nack_pending = nack;
            end
            start_phase(5'd0);
        end
        if (running != KIND_TICK) begin
            phase_ticks = phase_ticks + 16'd1;
            if (phase_ticks >= len) begin
                // slave level is sampled on the tick that closes a clock-high phase
                if (running == KIND_WRITE && phase_no == WR_ACK)
                    acked = ~sda;
                else if (running == KIND_READ && phase_no < RD_DATA_PHASES && !phase_no[0])
                    byte_shift = {byte_shift[6:0], sda};
                phase_ticks = '0;
                phase_no    = phase_no + 5'd1;
                if (phase_no >= phases_of(running)) begin
                    if (running == KIND_READ) last_rx = byte_shift;
                    running  = KIND_TICK;
                    phase_no = '0;
                    done     = 1'b1;
                end else begin
                    start_phase(phase_no);
                end
            end
        end
        w.pad  = '0;
        w.rx   = last_rx;
        w.ack  = acked;
        w.done = done;
        w.busy = (running != KIND_TICK);
        w.sda  = sda_drv;
        w.scl  = scl_drv;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        mismatches++;
        if (mismatches <= 100)
            $display("%0t: result %0d %s got %0h expected %0h",
                     $time, results_seen, what, got_v, want_v);
    endtask

    // scoreboard: predict on every accepted tick, compare every accepted result
    always @(posedge aclk) begin
        if (!aresetn) begin
            tick_len     = PHASE_LEN_RESET;
            phase_ticks  = '0;
            phase_no     = '0;
            running      = KIND_TICK;
            byte_shift   = '0;
            nack_pending = 1'b0;
            acked        = 1'b0;
            scl_drv      = 1'b1;
            sda_drv      = 1'b1;
            last_rx      = '0;
            idle_cycles  = 0;
        end else begin
            if (cfg_we) tick_len = cfg_wdata;
            // push before pop, a result can never belong to a word taken this edge
            if (s_tvalid && s_tready) begin
                predicted = predict_tick(s_tuser, s_tdata[7:0], s_tdata[8], s_tdata[9]);
                if (fixed_valid) levels_due.push_back(line_word_t'(fixed_word));
                else levels_due.push_back(predicted);
            end
            if (m_tvalid && m_tready) begin
                got = line_word_t'(m_tdata);
                if (levels_due.size() == 0) begin
                    report_mismatch("unexpected word", m_tdata, 0);
                end else begin
                    want = levels_due.pop_front();
                    if (got.scl !== want.scl) report_mismatch("scl", got.scl, want.scl);
                    if (got.sda !== want.sda) report_mismatch("sda_out", got.sda, want.sda);
                    if (got.busy !== want.busy) report_mismatch("busy", got.busy, want.busy);
                    if (got.done !== want.done) report_mismatch("done", got.done, want.done);
                    if (got.ack !== want.ack) report_mismatch("ack_ok", got.ack, want.ack);
                    if (got.rx !== want.rx) report_mismatch("rx_data", got.rx, want.rx);
                end
                results_seen++;
            end
            // watchdog on handshake activity
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("TEST FAILED");
                    $finish;
                end
            end
        end
    end

    // result side: random stall per word, none while quiet
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            @(negedge aclk);
        end
    end

    // drive one tick word; entered and left at a falling edge
    task automatic send_word(input logic [2:0] kind, input logic [7:0] tx, input logic nack,
                             input logic sda, input logic typed, input logic [15:0] typed_word);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid    <= 1'b1;
        s_tuser     <= kind;
        s_tdata     <= {6'd0, sda, nack, tx};
        fixed_valid = typed;
        fixed_word  = typed_word;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        @(negedge aclk);
    endtask

    // stop sending until every expected word is back
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (levels_due.size() != 0);
    endtask

    // issue one word and keep ticking with random line levels until the block is idle
    task automatic do_command(input logic [2:0] kind, input logic [7:0] tx, input logic nack);
        logic [2:0] filler;
        send_word(kind, tx, nack, 1'($urandom_range(0, 1)), 1'b0, 16'h0000);
        while (running != KIND_TICK) begin
            // now and then a command lands on a busy block and must be ignored
            filler = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : KIND_TICK;
            send_word(filler, 8'($urandom), 1'($urandom), 1'($urandom_range(0, 1)),
                      1'b0, 16'h0000);
        end
    endtask

    // mostly well-formed bus transactions, some noise and some missing stops
    task automatic run_transaction();
        int pick;
        int n_bytes;
        quiet = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 9) == 0) hold_until_drained();
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
            do_command(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
        end else if (pick == 1) begin
            do_command(KIND_INIT, 8'($urandom), 1'($urandom));
        end else begin
            do_command(KIND_START, 8'($urandom), 1'($urandom));
            do_command(KIND_WRITE, 8'($urandom), 1'($urandom));   // address byte
            n_bytes = $urandom_range(1, 2);
            for (int i = 0; i < n_bytes; i++) begin
                if ($urandom_range(0, 1) == 1)
                    do_command(KIND_WRITE, 8'($urandom), 1'($urandom));
                else
                    do_command(KIND_READ, 8'($urandom),
                               (i == n_bytes - 1) ? 1'b1 : 1'($urandom_range(0, 1)));
            end
            if (pick != 2) do_command(KIND_STOP, 8'($urandom), 1'($urandom));
        end
        // bus idle ticks between transactions
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 2))
                0:       do_command(KIND_SPARE6, 8'($urandom), 1'($urandom));
                1:       do_command(KIND_SPARE7, 8'($urandom), 1'($urandom));
                default: do_command(KIND_TICK, 8'($urandom), 1'($urandom));
            endcase
        end
    endtask

    // phase length change, block idle and nothing in flight
    task automatic set_phase_len(input logic [15:0] value);
        hold_until_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // slave level for a directed word: read data bits in order, else the ack level
    function automatic logic directed_sda(input dir_row_t r);
        logic [2:0] cmd;
        int         idx;
        cmd = (running == KIND_TICK) ? r.kind : running;
        idx = 7 - phase_no / 2;
        if (cmd == KIND_READ && phase_no < RD_DATA_PHASES) return r.sda_bits[idx];
        return r.sda_ack;
    endfunction

    initial begin
        dir_row_t    row;
        logic [15:0] setting;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = KIND_TICK;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        aresetn   = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed commands: reset state first, then at a phase length of one
        for (int k = 0; k < DIR_ROWS; k++) begin
            if (k == DIR_LEN_ONE_ROW) set_phase_len(16'd1);
            row = DIR_TABLE[k];
            send_word(row.kind, row.tx, row.nack, directed_sda(row), row.typed, row.want);
            while (running != KIND_TICK)
                send_word(row.filler, 8'($urandom), 1'($urandom), directed_sda(row),
                          1'b0, 16'h0000);
        end

        // random traffic at two phase lengths, zero included
        for (int k = 0; k < NUM_SETTINGS; k++) begin
            case (k)
                0:       setting = 16'd0;       // acts as one
                default: setting = 16'd2;
            endcase
            set_phase_len(setting);
            words_sent = 0;
            while (words_sent < WORDS_PER_SETTING) run_transaction();
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: bitbang_i2c_byte_master.f
+incdir+src
src/bbi2c_pkg.sv
src/bbi2c_seq.sv
src/bitbang_i2c_byte_master.sv
src/bbi2c_checker.sv
sim/bitbang_i2c_byte_master_tb.sv
